// ----- src/plm_pkg.sv -----
// Types, constants and shared arithmetic helpers for the Phong light model.
// Used by plm_unit and phong_light_model_top; depends on nothing else.
package plm_pkg;

  localparam int COLOR_BITS = 16;
  localparam logic [COLOR_BITS-1:0] COLOR_MAX = '1;
  localparam logic [16:0] ONE16 = 17'h1_0000;
  localparam logic [30:0] ONE30 = 31'h4000_0000;
  localparam logic [29:0] HALF30 = 30'h2000_0000;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMBIENT = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_DIFFUSE = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPEC_POWER = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LIGHT_X = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LIGHT_Y = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LIGHT_Z = 3'd5;

  localparam logic [15:0] AMBIENT_RST = 16'd13107;
  localparam logic [15:0] PEAK_DIFFUSE_RST = 16'd32768;
  localparam logic [7:0] SPEC_POWER_RST = 8'd100;
  localparam logic signed [31:0] LIGHT_X_RST = 32'sd1310720;
  localparam logic signed [31:0] LIGHT_Y_RST = 32'sd655360;
  localparam logic signed [31:0] LIGHT_Z_RST = 32'sd0;

  // Pipeline depths.
  localparam int SQRT_STEPS = 32;
  localparam int QUOT_STEPS = 31;
  localparam int UNIT_LAT = 5 + SQRT_STEPS + QUOT_STEPS;
  localparam int SPEC_BITS = 8;
  localparam int DIV_STEPS = 17;

  typedef struct packed {
    logic [COLOR_BITS-1:0] base_r;
    logic [COLOR_BITS-1:0] base_g;
    logic [COLOR_BITS-1:0] base_b;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
  } plm_in_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] shade_r;
    logic [COLOR_BITS-1:0] shade_g;
    logic [COLOR_BITS-1:0] shade_b;
    logic ok;
  } plm_out_t;

  // Brings an exact product sum back to Q30, rounding half away from zero.
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] x);
    logic [65:0] mag;
    logic [65:0] sh;
    mag = x[65] ? $unsigned(-x) : $unsigned(x);
    sh = (mag + 66'(HALF30)) >> 30;
    return x[65] ? -$signed(sh[35:0]) : $signed(sh[35:0]);
  endfunction

endpackage

// ----- src/plm_unit.sv -----
// Pipelined vector normaliser: magnitude alignment, sum of squares, square root
// and one quotient bit per stage for each component. Depends on plm_pkg.
module plm_unit (
  input  logic             clk,
  input  logic             en,
  input  logic [2:0][33:0] vec,
  output logic [2:0][31:0] unit,
  output logic             zero
);
  import plm_pkg::*;

  logic [2:0][32:0] abs_c;
  logic [32:0]      mx_c;
  logic [2:0]       neg1;
  logic [2:0][32:0] mag1;
  logic [32:0]      mx1;

  logic [5:0]       pos_c;
  logic [2:0]       neg2;
  logic [2:0][32:0] mag2;
  logic [5:0]       pos2;
  logic             zero2;

  logic [2:0][29:0] m_c;
  logic [2:0][29:0] m3;
  logic [2:0]       neg3;
  logic             zero3;

  logic [2:0][59:0] sq4;
  logic [2:0][29:0] m4;
  logic [2:0]       neg4;
  logic             zero4;

  logic [62:0]      sv [SQRT_STEPS+1];
  logic [62:0]      sr [SQRT_STEPS+1];
  logic [2:0][29:0] sm [SQRT_STEPS+1];
  logic [2:0]       sn [SQRT_STEPS+1];
  logic             sz [SQRT_STEPS+1];

  logic [30:0]      dl [QUOT_STEPS];
  logic [2:0][30:0] dr [QUOT_STEPS];
  logic [2:0][30:0] dq [QUOT_STEPS];
  logic [2:0]       dn [QUOT_STEPS];
  logic             dz [QUOT_STEPS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_c[i] = vec[i][33] ? 33'(34'd0 - vec[i]) : vec[i][32:0];
    end
    mx_c = abs_c[0];
    if (abs_c[1] > mx_c) mx_c = abs_c[1];
    if (abs_c[2] > mx_c) mx_c = abs_c[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= {vec[2][33], vec[1][33], vec[0][33]};
      mag1 <= abs_c;
      mx1  <= mx_c;
    end
  end

  always_comb begin
    pos_c = '0;
    for (int k = 0; k < 33; k++) begin
      if (mx1[k]) pos_c = 6'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2  <= neg1;
      mag2  <= mag1;
      pos2  <= pos_c;
      zero2 <= (mx1 == '0);
    end
  end

  // Shift all three magnitudes together so that the largest sits in [2^29, 2^30).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos2 >= 6'd29) begin
        m_c[i] = 30'(mag2[i] >> (pos2 - 6'd29));
      end else begin
        m_c[i] = 30'(mag2[i] << (6'd29 - pos2));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3    <= m_c;
      neg3  <= neg2;
      zero3 <= zero2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= 60'(m3[i]) * 60'(m3[i]);
      end
      m4    <= m3;
      neg4  <= neg3;
      zero4 <= zero3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sv[0] <= 63'(sq4[0]) + 63'(sq4[1]) + 63'(sq4[2]);
      sr[0] <= '0;
      sm[0] <= m4;
      sn[0] <= neg4;
      sz[0] <= zero4;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [62:0] BIT = 63'd1 << (62 - 2 * k);
    logic [62:0] trial;
    assign trial = sr[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sv[k] >= trial) begin
          sv[k+1] <= sv[k] - trial;
          sr[k+1] <= (sr[k] >> 1) + BIT;
        end else begin
          sv[k+1] <= sv[k];
          sr[k+1] <= sr[k] >> 1;
        end
        sm[k+1] <= sm[k];
        sn[k+1] <= sn[k];
        sz[k+1] <= sz[k];
      end
    end
  end

  // Each component is (m << 30) / len, one quotient bit per stage.
  for (genvar j = 0; j < QUOT_STEPS; j++) begin : g_quot
    logic [30:0]      len_in;
    logic [2:0][30:0] rem_in;
    logic [2:0][30:0] q_in;
    logic [2:0]       inb;
    logic [2:0]       n_in;
    logic             z_in;
    logic [2:0][31:0] sh;
    logic [2:0]       ge;

    if (j == 0) begin : g_first
      assign len_in = sr[SQRT_STEPS][30:0];
      assign n_in   = sn[SQRT_STEPS];
      assign z_in   = sz[SQRT_STEPS];
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign rem_in[c] = {2'b00, sm[SQRT_STEPS][c][29:1]};
        assign q_in[c]   = '0;
        assign inb[c]    = sm[SQRT_STEPS][c][0];
      end
    end else begin : g_next
      assign len_in = dl[j-1];
      assign n_in   = dn[j-1];
      assign z_in   = dz[j-1];
      assign rem_in = dr[j-1];
      assign q_in   = dq[j-1];
      assign inb    = '0;
    end

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        sh[c] = {rem_in[c], inb[c]};
        ge[c] = sh[c] >= {1'b0, len_in};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          dr[j][c] <= ge[c] ? 31'(sh[c] - {1'b0, len_in}) : sh[c][30:0];
          dq[j][c] <= {q_in[c][29:0], ge[c]};
        end
        dl[j] <= len_in;
        dn[j] <= n_in;
        dz[j] <= z_in;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      unit[c] = dn[QUOT_STEPS-1][c] ? 32'(33'd0 - {2'b00, dq[QUOT_STEPS-1][c]})
                                    : {1'b0, dq[QUOT_STEPS-1][c]};
    end
  end
  assign zero = dz[QUOT_STEPS-1];

endmodule

// ----- src/phong_light_model_top.sv -----
// Phong light model top level: configuration registers, dot products, specular
// power, colour mapping and output buffering. Depends on plm_pkg and plm_unit.
//
// One request is taken in every cycle in which sample_stall is low, and each
// gives one result. Most of the pipeline is made up of the bit-per-stage square
// root and quotient chains in the three normalisers and of the bit-per-stage
// colour divider. An output register with a one-entry skid buffer lets a request
// be taken while a finished result waits; sample_stall rises only once the skid
// buffer holds a result. Configuration writes must be made while no request is
// in flight.
module phong_light_model_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  plm_pkg::plm_in_t                    sample,
  output logic                                shade_valid,
  input  logic                                shade_stall,
  output plm_pkg::plm_out_t                   shade,
  input  logic                                cfg_write,
  input  logic [plm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [31:0]                         cfg_data
);
  import plm_pkg::*;

  localparam int PIPE_DEPTH = 1 + UNIT_LAT + 6 + SPEC_BITS + 3 + DIV_STEPS + 1;

  typedef struct packed {
    logic [2:0][15:0] c;
    logic             ok;
    logic             opp;
    logic [15:0]      diff;
    logic             on;
  } pow_side_t;

  typedef struct packed {
    logic [2:0][15:0] c;
    logic             ok;
    logic             scale;
    logic             madz;
    logic             madbig;
  } div_side_t;

  // Configuration.
  logic [15:0]        ambient;
  logic [15:0]        peak_diffuse;
  logic [7:0]         spec_power;
  logic signed [31:0] light_x;
  logic signed [31:0] light_y;
  logic signed [31:0] light_z;
  logic [16:0]        mad;

  // Flow control.
  logic                  en;
  logic                  accept;
  logic [PIPE_DEPTH-1:0] vld;
  plm_out_t              pf;
  plm_out_t              skid;
  logic                  skid_valid;

  // Entry and normalisers.
  logic [2:0][15:0] c0;
  logic [2:0][33:0] nv0;
  logic [2:0][33:0] ev0;
  logic [2:0][33:0] lv0;
  logic [2:0][31:0] un;
  logic [2:0][31:0] ue;
  logic [2:0][31:0] ul;
  logic             zn;
  logic             ze;
  logic             zl;
  logic [2:0][15:0] cl [UNIT_LAT];

  // Dot products and reflection.
  logic signed [31:0] n1 [3];
  logic signed [31:0] e1 [3];
  logic signed [31:0] l1 [3];
  logic signed [63:0] pe1 [3];
  logic signed [63:0] pl1 [3];
  logic [2:0][15:0]   c1;
  logic               ok1;

  logic signed [31:0] n2 [3];
  logic signed [31:0] e2 [3];
  logic signed [31:0] l2 [3];
  logic signed [33:0] nde2;
  logic signed [33:0] ndl2;
  logic [2:0][15:0]   c2;
  logic               ok2;

  logic               opp_c;
  logic               flip_c;
  logic signed [33:0] ndf_c;
  logic signed [31:0] nf_c [3];
  logic [30:0]        d_c;
  logic signed [65:0] pr3 [3];
  logic [46:0]        dp3;
  logic signed [31:0] e3 [3];
  logic signed [31:0] l3 [3];
  logic [2:0][15:0]   c3;
  logic               ok3;
  logic               opp3;

  logic signed [33:0] r4 [3];
  logic signed [31:0] e4 [3];
  logic [15:0]        diff4;
  logic [2:0][15:0]   c4;
  logic               ok4;
  logic               opp4;

  logic signed [65:0] er5 [3];
  logic [15:0]        diff5;
  logic [2:0][15:0]   c5;
  logic               ok5;
  logic               opp5;

  logic signed [33:0] edr_c;

  // Specular power.
  logic [30:0] pw_r [SPEC_BITS+1];
  logic [30:0] pw_b [SPEC_BITS+1];
  pow_side_t   pw_s [SPEC_BITS+1];

  logic [16:0]      ks_c;
  logic [47:0]      sp15;
  logic [15:0]      diff15;
  logic [2:0][15:0] c15;
  logic             ok15;
  logic             opp15;

  logic [16:0]      spec_c;
  logic [17:0]      inten16;
  logic [2:0][15:0] c16;
  logic             ok16;

  // Colour divider.
  logic             scale_c;
  logic [17:0]      over_c;
  logic [2:0][33:0] num_c;
  logic [2:0][33:0] qn [DIV_STEPS+1];
  logic [2:0][16:0] qr [DIV_STEPS+1];
  logic [2:0][16:0] qq [DIV_STEPS+1];
  logic [16:0]      qd [DIV_STEPS+1];
  div_side_t        qs [DIV_STEPS+1];

  logic [2:0][15:0] fin_c;

  assign mad = 17'(ambient) + 17'(peak_diffuse);

  always_ff @(posedge clk) begin
    if (rst) begin
      ambient      <= AMBIENT_RST;
      peak_diffuse <= PEAK_DIFFUSE_RST;
      spec_power   <= SPEC_POWER_RST;
      light_x      <= LIGHT_X_RST;
      light_y      <= LIGHT_Y_RST;
      light_z      <= LIGHT_Z_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_AMBIENT:      ambient      <= cfg_data[15:0];
        REG_PEAK_DIFFUSE: peak_diffuse <= cfg_data[15:0];
        REG_SPEC_POWER:   spec_power   <= cfg_data[7:0];
        REG_LIGHT_X:      light_x      <= $signed(cfg_data);
        REG_LIGHT_Y:      light_y      <= $signed(cfg_data);
        REG_LIGHT_Z:      light_z      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign en           = !skid_valid;
  assign sample_stall = skid_valid;
  assign accept       = sample_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], accept};
    end
  end

  // Entry: form the normal, point-to-eye and point-to-light vectors.
  always_ff @(posedge clk) begin
    if (en) begin
      c0[0]  <= sample.base_r;
      c0[1]  <= sample.base_g;
      c0[2]  <= sample.base_b;
      nv0[0] <= 34'(sample.norm_x);
      nv0[1] <= 34'(sample.norm_y);
      nv0[2] <= 34'(sample.norm_z);
      ev0[0] <= 34'(sample.eye_x) - 34'(sample.point_x);
      ev0[1] <= 34'(sample.eye_y) - 34'(sample.point_y);
      ev0[2] <= 34'(sample.eye_z) - 34'(sample.point_z);
      lv0[0] <= 34'(light_x) - 34'(sample.point_x);
      lv0[1] <= 34'(light_y) - 34'(sample.point_y);
      lv0[2] <= 34'(light_z) - 34'(sample.point_z);
    end
  end

  plm_unit u_norm  (.clk(clk), .en(en), .vec(nv0), .unit(un), .zero(zn));
  plm_unit u_eye   (.clk(clk), .en(en), .vec(ev0), .unit(ue), .zero(ze));
  plm_unit u_light (.clk(clk), .en(en), .vec(lv0), .unit(ul), .zero(zl));

  always_ff @(posedge clk) begin
    if (en) begin
      cl[0] <= c0;
      for (int k = 1; k < UNIT_LAT; k++) begin
        cl[k] <= cl[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n1[i]  <= $signed(un[i]);
        e1[i]  <= $signed(ue[i]);
        l1[i]  <= $signed(ul[i]);
        pe1[i] <= $signed(un[i]) * $signed(ue[i]);
        pl1[i] <= $signed(un[i]) * $signed(ul[i]);
      end
      c1  <= cl[UNIT_LAT-1];
      ok1 <= !(zn || ze || zl);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nde2 <= 34'(rnd30(66'(pe1[0]) + 66'(pe1[1]) + 66'(pe1[2])));
      ndl2 <= 34'(rnd30(66'(pl1[0]) + 66'(pl1[1]) + 66'(pl1[2])));
      n2   <= n1;
      e2   <= e1;
      l2   <= l1;
      c2   <= c1;
      ok2  <= ok1;
    end
  end

  // Opposite sides give ambient only; both behind the surface flips the normal.
  always_comb begin
    opp_c  = (ndl2 < 34'sd0 && nde2 > 34'sd0) || (ndl2 > 34'sd0 && nde2 < 34'sd0);
    flip_c = ndl2 < 34'sd0 && nde2 < 34'sd0;
    ndf_c  = flip_c ? -ndl2 : ndl2;
    for (int i = 0; i < 3; i++) begin
      nf_c[i] = flip_c ? -n2[i] : n2[i];
    end
    if (ndf_c > 34'sd0) begin
      d_c = (ndf_c > 34'sh4000_0000) ? ONE30 : ndf_c[30:0];
    end else begin
      d_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr3[i] <= 66'(ndf_c) * 66'(nf_c[i]);
      end
      dp3  <= 47'(peak_diffuse) * 47'(d_c);
      e3   <= e2;
      l3   <= l2;
      c3   <= c2;
      ok3  <= ok2;
      opp3 <= opp_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r4[i] <= 34'(rnd30(pr3[i] <<< 1) - 36'(l3[i]));
      end
      diff4 <= 16'((dp3 + 47'(HALF30)) >> 30);
      e4    <= e3;
      c4    <= c3;
      ok4   <= ok3;
      opp4  <= opp3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        er5[i] <= 66'(e4[i]) * 66'(r4[i]);
      end
      diff5 <= diff4;
      c5    <= c4;
      ok5   <= ok4;
      opp5  <= opp4;
    end
  end

  assign edr_c = 34'(rnd30(er5[0] + er5[1] + er5[2]));

  always_ff @(posedge clk) begin
    if (en) begin
      pw_r[0]      <= ONE30;
      pw_b[0]      <= (edr_c > 34'sh4000_0000) ? ONE30 : edr_c[30:0];
      pw_s[0].c    <= c5;
      pw_s[0].ok   <= ok5;
      pw_s[0].opp  <= opp5;
      pw_s[0].diff <= diff5;
      pw_s[0].on   <= edr_c > 34'sd0;
    end
  end

  // Square and multiply, lowest exponent bit first.
  for (genvar k = 0; k < SPEC_BITS; k++) begin : g_pow
    logic [61:0] mrb;
    logic [61:0] mbb;
    assign mrb = 62'(pw_r[k]) * 62'(pw_b[k]);
    assign mbb = 62'(pw_b[k]) * 62'(pw_b[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        pw_r[k+1] <= spec_power[k] ? 31'((mrb + 62'(HALF30)) >> 30) : pw_r[k];
        pw_b[k+1] <= 31'((mbb + 62'(HALF30)) >> 30);
        pw_s[k+1] <= pw_s[k];
      end
    end
  end

  assign ks_c = (mad >= ONE16) ? 17'd0 : ONE16 - mad;

  always_ff @(posedge clk) begin
    if (en) begin
      sp15   <= pw_s[SPEC_BITS].on ? 48'(ks_c) * 48'(pw_r[SPEC_BITS]) : 48'd0;
      diff15 <= pw_s[SPEC_BITS].diff;
      c15    <= pw_s[SPEC_BITS].c;
      ok15   <= pw_s[SPEC_BITS].ok;
      opp15  <= pw_s[SPEC_BITS].opp;
    end
  end

  assign spec_c = 17'((sp15 + 48'(HALF30)) >> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      inten16 <= opp15 ? 18'(ambient) : 18'(ambient) + 18'(diff15) + 18'(spec_c);
      c16     <= c15;
      ok16    <= ok15;
    end
  end

  // Scale toward black up to ambient+diffuse, blend toward white beyond it.
  always_comb begin
    scale_c = inten16 <= 18'(mad);
    over_c  = inten16 - 18'(mad);
    for (int i = 0; i < 3; i++) begin
      if (scale_c) begin
        num_c[i] = 34'(36'(c16[i]) * 36'(inten16));
      end else begin
        num_c[i] = 34'(36'(over_c) * 36'(ONE16 - 17'(c16[i])));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qn[0] <= num_c;
      for (int i = 0; i < 3; i++) begin
        qr[0][i] <= num_c[i][33:17];
      end
      qq[0]        <= '0;
      qd[0]        <= scale_c ? mad : ONE16 - mad;
      qs[0].c      <= c16;
      qs[0].ok     <= ok16;
      qs[0].scale  <= scale_c;
      qs[0].madz   <= (mad == '0);
      qs[0].madbig <= (mad >= ONE16);
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int QB = DIV_STEPS - 1 - j;
    logic [2:0][17:0] sh;
    logic [2:0]       ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i] = {qr[j][i], qn[j][i][QB]};
        ge[i] = sh[i] >= {1'b0, qd[j]};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          qr[j+1][i] <= ge[i] ? 17'(sh[i] - {1'b0, qd[j]}) : sh[i][16:0];
          qq[j+1][i] <= {qq[j][i][15:0], ge[i]};
        end
        qn[j+1] <= qn[j];
        qd[j+1] <= qd[j];
        qs[j+1] <= qs[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [17:0] sum;
      sum = 18'(qs[DIV_STEPS].c[i]) + 18'(qq[DIV_STEPS][i]);
      if (!qs[DIV_STEPS].ok) begin
        fin_c[i] = '0;
      end else if (qs[DIV_STEPS].scale) begin
        fin_c[i] = qs[DIV_STEPS].madz ? 16'd0 : qq[DIV_STEPS][i][15:0];
      end else if (qs[DIV_STEPS].madbig) begin
        fin_c[i] = COLOR_MAX;
      end else begin
        fin_c[i] = (sum > 18'(COLOR_MAX)) ? COLOR_MAX : sum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pf.shade_r <= fin_c[0];
      pf.shade_g <= fin_c[1];
      pf.shade_b <= fin_c[2];
      pf.ok      <= qs[DIV_STEPS].ok;
    end
  end

  // Output register with a one-entry skid buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      shade_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      if (!shade_stall) begin
        shade      <= skid;
        skid_valid <= 1'b0;
      end
    end else if (shade_valid && shade_stall) begin
      if (vld[PIPE_DEPTH-1]) begin
        skid       <= pf;
        skid_valid <= 1'b1;
      end
    end else begin
      shade_valid <= vld[PIPE_DEPTH-1];
      shade       <= pf;
    end
  end

  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> shade_valid)
    else $error("skid buffer holds a result while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(shade_valid && shade_stall && vld[PIPE_DEPTH-1]))
    else $error("skid buffer filled without a stalled output and a finished result");

  a_fail_black: assert property (@(posedge clk) disable iff (rst)
    (shade_valid && !shade.ok) |->
      (shade.shade_r == '0 && shade.shade_g == '0 && shade.shade_b == '0))
    else $error("failed result carries a non-black colour");

endmodule
